// File: hw/rtl/qrs_pkg.sv
// ----------------------------------------------------------------------------
// qrs_pkg
// Shared widths, payload types and codes for the quadratic root solver.
// ----------------------------------------------------------------------------
package qrs_pkg;

  localparam int COEF_WIDTH = 32;
  localparam int FRAC_BITS  = 16;

  localparam int CTOL_W = 17;
  localparam int DTOL_W = 33;

  localparam int PROD_W   = 2 * COEF_WIDTH;       // b*b, a*c
  localparam int DSIG_W   = PROD_W + 3;           // signed discriminant
  localparam int DISC_W   = PROD_W + 2;           // |D|, even for the root
  localparam int ROOT_W   = DISC_W / 2;           // floor sqrt width
  localparam int SQ_REM_W = ROOT_W + 2;
  localparam int NUM_W    = COEF_WIDTH + 2;       // numerator magnitude
  localparam int NUMS_W   = NUM_W + 1;
  localparam int DEN_W    = COEF_WIDTH + 1;       // denominator magnitude
  localparam int QUO_W    = NUM_W + FRAC_BITS;    // quotient bits

  localparam int CT_CMP_W = (COEF_WIDTH > CTOL_W) ? COEF_WIDTH : CTOL_W;
  localparam int DT_CMP_W = (DISC_W > DTOL_W) ? DISC_W : DTOL_W;

  localparam int PADDR_W = 4;
  localparam int PDATA_W = 64;

  localparam logic REG_COEF_TOL = 1'b0;
  localparam logic REG_DISC_TOL = 1'b1;

  localparam logic [1:0] CNT_NONE = 2'd0;
  localparam logic [1:0] CNT_ONE  = 2'd1;
  localparam logic [1:0] CNT_TWO  = 2'd2;
  localparam logic [1:0] CNT_INF  = 2'd3;

  typedef enum logic [2:0] {
    M_NONE,
    M_INF,
    M_LIN,
    M_DBL,
    M_TWO
  } mode_t;

  typedef struct packed {
    logic signed [COEF_WIDTH-1:0] coef_a;
    logic signed [COEF_WIDTH-1:0] coef_b;
    logic signed [COEF_WIDTH-1:0] coef_c;
  } qrs_in_t;

  typedef struct packed {
    logic [1:0]                   root_count;
    logic signed [COEF_WIDTH-1:0] first_root;
    logic signed [COEF_WIDTH-1:0] second_root;
    logic                         saturated;
  } qrs_out_t;

  // Sideband that rides along the square root pipeline
  typedef struct packed {
    mode_t                        mode;
    logic signed [COEF_WIDTH-1:0] a;
    logic signed [COEF_WIDTH-1:0] b;
    logic signed [COEF_WIDTH-1:0] c;
  } qrs_side_t;

  // One divider stage, both lanes; x holds dividend bits on top, quotient below
  typedef struct packed {
    mode_t            mode;
    logic             neg1;
    logic             neg2;
    logic [DEN_W-1:0] den;
    logic [DEN_W-1:0] rem1;
    logic [DEN_W-1:0] rem2;
    logic [QUO_W-1:0] x1;
    logic [QUO_W-1:0] x2;
  } qrs_div_t;

endpackage

// File: hw/rtl/qrs_sqrt.sv
// ----------------------------------------------------------------------------
// qrs_sqrt
// Pipelined floor square root, one root bit per stage.
// ----------------------------------------------------------------------------
module qrs_sqrt (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic [qrs_pkg::DISC_W-1:0] in_rad,
  input  qrs_pkg::qrs_side_t         in_side,
  output logic                       out_valid,
  output logic [qrs_pkg::ROOT_W-1:0] out_root,
  output qrs_pkg::qrs_side_t         out_side
);
  import qrs_pkg::*;

  logic                v    [ROOT_W+1];
  logic [DISC_W-1:0]   rad  [ROOT_W+1];
  logic [SQ_REM_W-1:0] rem  [ROOT_W+1];
  logic [ROOT_W-1:0]   root [ROOT_W+1];
  qrs_side_t           side [ROOT_W+1];

  assign v[0]    = in_valid;
  assign rad[0]  = in_rad;
  assign rem[0]  = '0;
  assign root[0] = '0;
  assign side[0] = in_side;

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    logic [SQ_REM_W+1:0] acc;
    logic [SQ_REM_W+1:0] trial;
    logic                take;

    always_comb begin
      acc   = {rem[k], rad[k][DISC_W-1 -: 2]};
      trial = {2'b00, root[k], 2'b01};
      take  = (acc >= trial);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else begin
        v[k+1] <= v[k];
      end
      rad[k+1]  <= {rad[k][DISC_W-3:0], 2'b00};
      rem[k+1]  <= take ? SQ_REM_W'(acc - trial) : SQ_REM_W'(acc);
      root[k+1] <= {root[k][ROOT_W-2:0], take};
      side[k+1] <= side[k];
    end
  end

  assign out_valid = v[ROOT_W];
  assign out_root  = root[ROOT_W];
  assign out_side  = side[ROOT_W];

endmodule

// File: hw/rtl/qrs_div.sv
// ----------------------------------------------------------------------------
// qrs_div
// Two-lane pipelined restoring divider with a shared divisor, one quotient
// bit per stage.
// ----------------------------------------------------------------------------
module qrs_div (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  qrs_pkg::qrs_div_t in_st,
  output logic              out_valid,
  output qrs_pkg::qrs_div_t out_st
);
  import qrs_pkg::*;

  logic     v  [QUO_W+1];
  qrs_div_t st [QUO_W+1];

  assign v[0]  = in_valid;
  assign st[0] = in_st;

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    logic [DEN_W:0] acc1;
    logic [DEN_W:0] acc2;
    logic [DEN_W:0] dext;
    logic           take1;
    logic           take2;
    qrs_div_t       nxt;

    always_comb begin
      dext  = {1'b0, st[k].den};
      acc1  = {st[k].rem1, st[k].x1[QUO_W-1]};
      acc2  = {st[k].rem2, st[k].x2[QUO_W-1]};
      take1 = (acc1 >= dext);
      take2 = (acc2 >= dext);
      nxt      = st[k];
      nxt.rem1 = take1 ? DEN_W'(acc1 - dext) : DEN_W'(acc1);
      nxt.rem2 = take2 ? DEN_W'(acc2 - dext) : DEN_W'(acc2);
      nxt.x1   = {st[k].x1[QUO_W-2:0], take1};
      nxt.x2   = {st[k].x2[QUO_W-2:0], take2};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else begin
        v[k+1] <= v[k];
      end
      st[k+1] <= nxt;
    end
  end

  assign out_valid = v[QUO_W];
  assign out_st    = st[QUO_W];

endmodule

// File: hw/rtl/quadratic_root_solver_top.sv
// ----------------------------------------------------------------------------
// quadratic_root_solver_top
// Real roots of a*x^2 + b*x + c = 0 in signed Q16.16, fully pipelined.
// ----------------------------------------------------------------------------
// A coefficient set is taken on any cycle with start high (busy stays low),
// one per clock. Its result appears on result with done high for a single
// cycle, after passing through three front stages (operand register,
// multipliers, discriminant), 33 square root stages with one root bit each,
// a numerator stage, 50 divider stages with one quotient bit each, and the
// output register. The receiver cannot stall: results must be taken when
// done is high. Tolerance registers sit at byte addresses 0x0 and 0x8 and
// may only be written while no item is in flight.
module quadratic_root_solver_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  qrs_pkg::qrs_in_t            operands,
  output logic                        done,
  output qrs_pkg::qrs_out_t           result,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [qrs_pkg::PADDR_W-1:0] paddr,
  input  logic [qrs_pkg::PDATA_W-1:0] pwdata,
  output logic [qrs_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);
  import qrs_pkg::*;

  localparam int W = COEF_WIDTH;

  // ---------------- configuration ----------------
  logic [CTOL_W-1:0] coef_tol;
  logic [DTOL_W-1:0] disc_tol;
  logic [CTOL_W-1:0] ctol_eff;
  logic [DTOL_W-1:0] dtol_eff;

  assign pready = 1'b1;
  assign busy   = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_tol <= CTOL_W'(1);
      disc_tol <= DTOL_W'(1);
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3])
        REG_COEF_TOL: coef_tol <= pwdata[CTOL_W-1:0];
        REG_DISC_TOL: disc_tol <= pwdata[DTOL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3])
      REG_COEF_TOL: prdata = PDATA_W'(coef_tol);
      REG_DISC_TOL: prdata = PDATA_W'(disc_tol);
      default:      prdata = '0;
    endcase
  end

  // a zero register behaves as one
  assign ctol_eff = (coef_tol == '0) ? CTOL_W'(1) : coef_tol;
  assign dtol_eff = (disc_tol == '0) ? DTOL_W'(1) : disc_tol;

  // ---------------- stage 0: operand register ----------------
  logic    v0;
  qrs_in_t s0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else begin
      v0 <= start && !busy;
    end
    if (start && !busy) begin
      s0 <= operands;
    end
  end

  // ---------------- stage 1: magnitudes, zero tests, products ----------------
  logic [W-1:0]             amag, bmag, cmag;
  logic [PROD_W-1:0]        pbb_c;
  logic signed [PROD_W-1:0] pac_c;

  assign amag  = s0.coef_a[W-1] ? -s0.coef_a : s0.coef_a;
  assign bmag  = s0.coef_b[W-1] ? -s0.coef_b : s0.coef_b;
  assign cmag  = s0.coef_c[W-1] ? -s0.coef_c : s0.coef_c;
  assign pbb_c = PROD_W'(bmag) * PROD_W'(bmag);
  assign pac_c = PROD_W'(s0.coef_a) * PROD_W'(s0.coef_c);

  logic                     v1;
  logic                     az1, bz1, cz1;
  logic [PROD_W-1:0]        pbb1;
  logic signed [PROD_W-1:0] pac1;
  qrs_in_t                  s1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= v0;
    end
    az1  <= CT_CMP_W'(amag) < CT_CMP_W'(ctol_eff);
    bz1  <= CT_CMP_W'(bmag) < CT_CMP_W'(ctol_eff);
    cz1  <= CT_CMP_W'(cmag) < CT_CMP_W'(ctol_eff);
    pbb1 <= pbb_c;
    pac1 <= pac_c;
    s1   <= s0;
  end

  // ---------------- stage 2: discriminant and case split ----------------
  logic signed [DSIG_W-1:0] dsig;
  logic [DSIG_W-1:0]        dabs;
  logic [DISC_W-1:0]        dmag;
  logic                     dneg, dzero;
  mode_t                    mode2;

  always_comb begin
    dsig  = DSIG_W'($signed({1'b0, pbb1})) - (DSIG_W'(pac1) <<< 2);
    dneg  = dsig[DSIG_W-1];
    dabs  = dneg ? -dsig : dsig;
    dmag  = dabs[DISC_W-1:0];
    dzero = DT_CMP_W'(dmag) < DT_CMP_W'(dtol_eff);
    priority if (az1) begin
      if (!bz1) mode2 = M_LIN;
      else if (cz1) mode2 = M_INF;
      else mode2 = M_NONE;
    end else if (dzero) begin
      mode2 = M_DBL;
    end else if (dneg) begin
      mode2 = M_NONE;
    end else begin
      mode2 = M_TWO;
    end
  end

  logic              v2;
  logic [DISC_W-1:0] rad2;
  qrs_side_t         side2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    rad2       <= (mode2 == M_TWO) ? dmag : '0;
    side2.mode <= mode2;
    side2.a    <= s1.coef_a;
    side2.b    <= s1.coef_b;
    side2.c    <= s1.coef_c;
  end

  // ---------------- square root ----------------
  logic              v3;
  logic [ROOT_W-1:0] root3;
  qrs_side_t         side3;

  qrs_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v2),
    .in_rad    (rad2),
    .in_side   (side2),
    .out_valid (v3),
    .out_root  (root3),
    .out_side  (side3)
  );

  // ---------------- numerators and divisor ----------------
  logic signed [NUMS_W-1:0] bx, sx, num1, num2;
  logic [NUMS_W-1:0]        n1abs, n2abs;
  logic signed [DEN_W-1:0]  den;
  logic [DEN_W-1:0]         denabs;
  qrs_div_t                 dv_c;

  always_comb begin
    bx = NUMS_W'(side3.b);
    sx = $signed(NUMS_W'(root3));
    unique case (side3.mode)
      M_LIN: begin
        num1 = -NUMS_W'(side3.c);
        num2 = '0;
        den  = DEN_W'(side3.b);
      end
      M_TWO: begin
        num1 = sx - bx;
        num2 = -bx - sx;
        den  = $signed({side3.a, 1'b0});
      end
      default: begin
        num1 = -bx;
        num2 = '0;
        den  = $signed({side3.a, 1'b0});
      end
    endcase
    n1abs     = num1[NUMS_W-1] ? -num1 : num1;
    n2abs     = num2[NUMS_W-1] ? -num2 : num2;
    denabs    = den[DEN_W-1] ? -den : den;
    dv_c.mode = side3.mode;
    dv_c.neg1 = num1[NUMS_W-1] ^ den[DEN_W-1];
    dv_c.neg2 = num2[NUMS_W-1] ^ den[DEN_W-1];
    dv_c.den  = denabs;
    dv_c.rem1 = '0;
    dv_c.rem2 = '0;
    dv_c.x1   = QUO_W'(n1abs[NUM_W-1:0]) << FRAC_BITS;
    dv_c.x2   = QUO_W'(n2abs[NUM_W-1:0]) << FRAC_BITS;
  end

  logic     v4;
  qrs_div_t dv4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= v3;
    end
    dv4 <= dv_c;
  end

  // ---------------- divider ----------------
  logic     v5;
  qrs_div_t dv5;

  qrs_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v4),
    .in_st     (dv4),
    .out_valid (v5),
    .out_st    (dv5)
  );

  // ---------------- saturation and result ----------------
  logic [QUO_W-1:0] lim_pos, lim1, lim2, q1, q2;
  logic             sat1, sat2;
  logic [W-1:0]     r1, r2;
  qrs_out_t         res_c;

  always_comb begin
    lim_pos = QUO_W'({1'b0, {(W-1){1'b1}}});
    lim1    = dv5.neg1 ? lim_pos + QUO_W'(1) : lim_pos;
    lim2    = dv5.neg2 ? lim_pos + QUO_W'(1) : lim_pos;
    sat1    = dv5.x1 > lim1;
    sat2    = dv5.x2 > lim2;
    q1      = sat1 ? lim1 : dv5.x1;
    q2      = sat2 ? lim2 : dv5.x2;
    r1      = dv5.neg1 ? -q1[W-1:0] : q1[W-1:0];
    r2      = dv5.neg2 ? -q2[W-1:0] : q2[W-1:0];
    res_c   = '0;
    unique case (dv5.mode)
      M_INF: res_c.root_count = CNT_INF;
      M_LIN, M_DBL: begin
        res_c.root_count = CNT_ONE;
        res_c.first_root = r1;
        res_c.saturated  = sat1;
      end
      M_TWO: begin
        res_c.root_count  = CNT_TWO;
        res_c.first_root  = r1;
        res_c.second_root = r2;
        res_c.saturated   = sat1 | sat2;
      end
      default: res_c.root_count = CNT_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v5;
    end
    result <= res_c;
  end

endmodule
